### rtl/compass_heading_calc_macros.svh
// Assertion macros used by the compass heading top level.
`ifndef COMPASS_HEADING_CALC_MACROS_SVH
`define COMPASS_HEADING_CALC_MACROS_SVH

// Implication checked in the same cycle, off during reset.
`define CCH_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication with the consequent checked after the delay argument, off during reset.
`define CCH_ASSERT_DLY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

### rtl/cch_pkg.sv
// Types and constants shared by the compass heading pipeline.
`timescale 1ns / 1ps

package cch_pkg;

  // Angle accumulator: 1/64 degree with 12 fraction bits.
  localparam int ZW         = 28;
  localparam int ANG_FRAC   = 12;
  localparam int GUARD_BITS = 24;
  localparam int ROUND_HALF = 2048;

  localparam int unsigned FULL_TURN = 23040;
  localparam logic signed [ZW-1:0] DEG90 = 28'sd23592960;

  // atan(2^-i) in 1/262144 degree, rounded.
  localparam logic signed [ZW-1:0] ATAN_TAB [24] = '{
    28'sd11796480, 28'sd6963869, 28'sd3679517, 28'sd1867780,
    28'sd937515,   28'sd469214,  28'sd234664,  28'sd117339,
    28'sd58671,    28'sd29335,   28'sd14668,   28'sd7334,
    28'sd3667,     28'sd1833,    28'sd917,     28'sd458,
    28'sd229,      28'sd115,     28'sd57,      28'sd29,
    28'sd14,       28'sd7,       28'sd4,       28'sd2
  };

  typedef enum logic [1:0] {
    REG_OFFSET_X     = 2'd0,
    REG_OFFSET_Y     = 2'd1,
    REG_SCALE_Y      = 2'd2,
    REG_MOUNT_OFFSET = 2'd3
  } cch_reg_t;

  // Flags that travel down the pipeline with each request.
  typedef struct packed {
    logic valid;
    logic zero;
    logic sat;
  } cch_side_t;

endpackage

### rtl/cch_cordic_stage.sv
// One registered vectoring CORDIC iteration.
`timescale 1ns / 1ps

module cch_cordic_stage
  import cch_pkg::*;
#(
  parameter int DW   = 48,
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic signed [DW-1:0] x_in,
  input  logic signed [DW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  input  cch_side_t            side_in,
  output logic signed [DW-1:0] x_out,
  output logic signed [DW-1:0] y_out,
  output logic signed [ZW-1:0] z_out,
  output cch_side_t            side_out
);

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic                 y_pos;

  assign dx    = y_in >>> STEP;
  assign dy    = x_in >>> STEP;
  assign y_pos = !y_in[DW-1] && (y_in != '0);

  always_ff @(posedge clk) begin
    if (y_pos) begin
      x_out <= x_in + dx;
      y_out <= y_in - dy;
      z_out <= z_in + ATAN_TAB[STEP];
    end else begin
      x_out <= x_in - dx;
      y_out <= y_in + dy;
      z_out <= z_in - ATAN_TAB[STEP];
    end
    if (rst) begin
      side_out.valid <= 1'b0;
    end else begin
      side_out <= side_in;
    end
  end

endmodule

### rtl/compass_heading_calc.sv
// Top level of the compass heading pipeline.
`timescale 1ns / 1ps
`include "compass_heading_calc_macros.svh"

// Compass heading from one raw X/Y magnetometer pair per request. A request is
// taken in every cycle (busy stays low) and its heading appears with done at
// the end of the pipeline; results follow in request order and must be taken
// when shown, since the receiver cannot stall. The pipeline registers offset,
// soft-iron scaling and quadrant setup, then each CORDIC iteration, then
// rounding with the mounting offset, and last the wrap.
// Calibration registers may be changed only while no request is in flight.

module compass_heading_calc
  import cch_pkg::*;
#(
  parameter int CORDIC_STEPS = 16,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [SAMPLE_BITS-1:0] mag_x,
  input  logic signed [SAMPLE_BITS-1:0] mag_y,
  input  logic                          wr_en,
  input  logic [1:0]                    wr_index,
  input  logic [15:0]                   wr_data,
  output logic                          done,
  output logic [14:0]                   heading,
  output logic                          y_saturated
);

  localparam int CW  = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 1;
  localparam int PW  = CW + 17;
  localparam int TW  = PW - 11;
  localparam int SW  = SAMPLE_BITS + 4;
  localparam int MW  = (CW > SW) ? CW : SW;
  localparam int IW  = MW + 3;
  localparam int DW  = IW + GUARD_BITS;
  localparam int AW  = ZW - ANG_FRAC + 1;
  localparam int LAT = CORDIC_STEPS + 6;

  logic signed [15:0] offset_x;
  logic signed [15:0] offset_y;
  logic [15:0]        scale_y;
  logic signed [15:0] mount_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x     <= '0;
      offset_y     <= '0;
      scale_y      <= 16'd4096;
      mount_offset <= '0;
    end else if (wr_en) begin
      case (cch_reg_t'(wr_index))
        REG_OFFSET_X:     offset_x     <= wr_data;
        REG_OFFSET_Y:     offset_y     <= wr_data;
        REG_SCALE_Y:      scale_y      <= wr_data;
        REG_MOUNT_OFFSET: mount_offset <= wr_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Hard-iron correction.
  logic                 s1_valid;
  logic signed [CW-1:0] s1_cx;
  logic signed [CW-1:0] s1_cy;

  always_ff @(posedge clk) begin
    s1_cx <= CW'(mag_x) - CW'(offset_x);
    s1_cy <= CW'(mag_y) - CW'(offset_y);
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
  end

  // Soft-iron scaling product.
  logic                 s2_valid;
  logic signed [CW-1:0] s2_cx;
  logic signed [PW-1:0] s2_prod;

  always_ff @(posedge clk) begin
    s2_cx   <= s1_cx;
    s2_prod <= PW'(s1_cy) * PW'($signed({1'b0, scale_y}));
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  // Round half up to integer counts, then clip to SW bits.
  logic signed [PW:0]   rnd_y;
  logic signed [TW-1:0] ys_full;
  logic                 sat_hi;
  logic                 sat_lo;
  logic signed [SW-1:0] ys_clip;

  assign rnd_y   = (PW + 1)'(s2_prod) + (PW + 1)'(ROUND_HALF);
  assign ys_full = $signed(rnd_y[PW:ANG_FRAC]);
  assign sat_hi  = !ys_full[TW-1] && (ys_full[TW-1:SW-1] != '0);
  assign sat_lo  = ys_full[TW-1] && (ys_full[TW-1:SW-1] != '1);

  always_comb begin
    if (sat_hi) begin
      ys_clip = {1'b0, {(SW - 1){1'b1}}};
    end else if (sat_lo) begin
      ys_clip = {1'b1, {(SW - 1){1'b0}}};
    end else begin
      ys_clip = ys_full[SW-1:0];
    end
  end

  cch_side_t            s3_side;
  logic signed [CW-1:0] s3_cx;
  logic signed [SW-1:0] s3_ys;

  always_ff @(posedge clk) begin
    s3_cx        <= s2_cx;
    s3_ys        <= ys_clip;
    s3_side.zero <= (s2_cx == '0) && (ys_full == '0);
    s3_side.sat  <= sat_hi || sat_lo;
    if (rst) begin
      s3_side.valid <= 1'b0;
    end else begin
      s3_side.valid <= s2_valid;
    end
  end

  // Left half plane is turned by 90 degrees so the iterations converge.
  logic signed [IW-1:0] xe;
  logic signed [IW-1:0] ye;
  logic signed [IW-1:0] x0;
  logic signed [IW-1:0] y0;
  logic signed [ZW-1:0] z0;

  assign xe = IW'(s3_cx);
  assign ye = IW'(s3_ys);

  always_comb begin
    x0 = xe;
    y0 = ye;
    z0 = '0;
    if (xe[IW-1]) begin
      if (!ye[IW-1]) begin
        x0 = ye;
        y0 = -xe;
        z0 = DEG90;
      end else begin
        x0 = -ye;
        y0 = xe;
        z0 = -DEG90;
      end
    end
  end

  logic signed [DW-1:0] cx [CORDIC_STEPS+1];
  logic signed [DW-1:0] cy [CORDIC_STEPS+1];
  logic signed [ZW-1:0] cz [CORDIC_STEPS+1];
  cch_side_t            cs [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    cx[0] <= {x0, {GUARD_BITS{1'b0}}};
    cy[0] <= {y0, {GUARD_BITS{1'b0}}};
    cz[0] <= z0;
    if (rst) begin
      cs[0].valid <= 1'b0;
    end else begin
      cs[0] <= s3_side;
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_iter
    cch_cordic_stage #(
      .DW   (DW),
      .STEP (g)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .x_in     (cx[g]),
      .y_in     (cy[g]),
      .z_in     (cz[g]),
      .side_in  (cs[g]),
      .x_out    (cx[g+1]),
      .y_out    (cy[g+1]),
      .z_out    (cz[g+1]),
      .side_out (cs[g+1])
    );
  end

  // Round to 1/64 degree, add mounting offset, bias to a positive value.
  logic signed [ZW:0]   rnd_z;
  logic signed [AW-1:0] ang;
  logic [17:0]          h_sum;

  assign rnd_z = (ZW + 1)'(cz[CORDIC_STEPS]) + (ZW + 1)'(ROUND_HALF);
  assign ang   = cs[CORDIC_STEPS].zero ? '0 : $signed(rnd_z[ZW:ANG_FRAC]);
  assign h_sum = 18'(ang) + 18'(mount_offset) + 18'(2 * FULL_TURN);

  cch_side_t   s5_side;
  logic [16:0] s5_h;

  always_ff @(posedge clk) begin
    s5_h <= h_sum[16:0];
    if (rst) begin
      s5_side.valid <= 1'b0;
    end else begin
      s5_side <= cs[CORDIC_STEPS];
    end
  end

  // The biased sum is below four turns, so two conditional subtracts wrap it.
  logic [16:0] h_r1;
  logic [16:0] h_r2;

  assign h_r1 = (s5_h >= 17'(2 * FULL_TURN)) ? s5_h - 17'(2 * FULL_TURN) : s5_h;
  assign h_r2 = (h_r1 >= 17'(FULL_TURN)) ? h_r1 - 17'(FULL_TURN) : h_r1;

  always_ff @(posedge clk) begin
    heading     <= h_r2[14:0];
    y_saturated <= s5_side.sat;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s5_side.valid;
    end
  end

  `CCH_ASSERT(a_heading_range, done, heading < 15'(FULL_TURN), "heading out of range")
  `CCH_ASSERT(a_wrap_input, s5_side.valid, s5_h < 17'(4 * FULL_TURN), "biased sum too large")
  `CCH_ASSERT_DLY(a_latency, start && !busy, LAT, done, "result missing after request")
  `CCH_ASSERT(a_no_spurious, done, $past(start, LAT), "result without request")

endmodule

### tb/sv/compass_heading_checker.sv
// Checker that predicts and compares every compass heading result.
`timescale 1ns / 1ps

module compass_heading_checker
  import cch_pkg::*;
#(
  parameter int CORDIC_STEPS = 16,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic signed [SAMPLE_BITS-1:0] mag_x,
  input  logic signed [SAMPLE_BITS-1:0] mag_y,
  input  logic                          wr_en,
  input  logic [1:0]                    wr_index,
  input  logic [15:0]                   wr_data,
  input  logic                          done,
  input  logic [14:0]                   heading,
  input  logic                          y_saturated,
  output int                            mismatches,
  output int                            pending
);

  localparam int SAT_W = SAMPLE_BITS + 4;

  typedef struct packed {
    logic [14:0] heading;
    logic        y_sat;
  } heading_rec_t;

  heading_rec_t heading_q[$];

  // Calibration as seen on the write port.
  logic signed [15:0] cal_off_x;
  logic signed [15:0] cal_off_y;
  logic [15:0]        cal_scale_y;
  logic signed [15:0] cal_mount;

  initial mismatches = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Vectoring CORDIC; the left half plane is first turned by 90 degrees.
  function automatic longint cordic_vector_angle(input longint x_in, input longint y_in);
    longint x, y, z, t, dx, dy;
    x = x_in;
    y = y_in;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = longint'(DEG90);
      end else begin
        t = x; x = -y; y = t; z = -longint'(DEG90);
      end
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx; y = y - dy; z = z + longint'(ATAN_TAB[i]);
      end else begin
        x = x - dx; y = y + dy; z = z - longint'(ATAN_TAB[i]);
      end
    end
    return z;
  endfunction

  function automatic heading_rec_t predict_heading(input logic signed [SAMPLE_BITS-1:0] mx,
                                                   input logic signed [SAMPLE_BITS-1:0] my);
    longint cx, cy, ys, ymax, ymin, ang, h;
    heading_rec_t rec;
    cx = longint'(mx) - longint'(cal_off_x);
    cy = longint'(my) - longint'(cal_off_y);
    ys = (cy * longint'(cal_scale_y) + ROUND_HALF) >>> ANG_FRAC;
    ymax = (longint'(1) <<< (SAT_W - 1)) - 1;
    ymin = -ymax - 1;
    rec.y_sat = 1'b0;
    if (ys > ymax) begin
      ys = ymax; rec.y_sat = 1'b1;
    end else if (ys < ymin) begin
      ys = ymin; rec.y_sat = 1'b1;
    end
    ang = 0;
    // A zero vector has no direction; its angle is taken as zero.
    if (cx != 0 || ys != 0)
      ang = (cordic_vector_angle(cx <<< GUARD_BITS, ys <<< GUARD_BITS) + ROUND_HALF) >>> ANG_FRAC;
    h = ang + longint'(cal_mount);
    h = h % longint'(FULL_TURN);
    if (h < 0)
      h = h + longint'(FULL_TURN);
    rec.heading = h[14:0];
    return rec;
  endfunction

  always @(posedge clk) begin
    heading_rec_t want;
    if (rst) begin
      cal_off_x   <= '0;
      cal_off_y   <= '0;
      cal_scale_y <= 16'd4096;
      cal_mount   <= '0;
      heading_q.delete();
      pending     <= 0;
    end else begin
      if (done) begin
        if (heading_q.size() == 0) begin
          report_mismatch($sformatf("result with no request pending: heading=%0d sat=%0b",
                                    heading, y_saturated));
        end else begin
          want = heading_q.pop_front();
          if (heading !== want.heading)
            report_mismatch($sformatf("heading got %0d expected %0d", heading, want.heading));
          if (y_saturated !== want.y_sat)
            report_mismatch($sformatf("y_saturated got %0b expected %0b",
                                      y_saturated, want.y_sat));
        end
      end
      if (start && !busy)
        heading_q.push_back(predict_heading(mag_x, mag_y));
      if (wr_en) begin
        case (cch_reg_t'(wr_index))
          REG_OFFSET_X:     cal_off_x   <= wr_data;
          REG_OFFSET_Y:     cal_off_y   <= wr_data;
          REG_SCALE_Y:      cal_scale_y <= wr_data;
          REG_MOUNT_OFFSET: cal_mount   <= wr_data;
          default: ;
        endcase
      end
      pending <= heading_q.size();
    end
  end

endmodule

### tb/sv/tb_compass_heading_calc.sv
// Top of the compass heading testbench: clock, reset, requests and verdict.
`timescale 1ns / 1ps

module tb_compass_heading_calc
  import cch_pkg::*;
();

  localparam int CORDIC_STEPS    = 16;
  localparam int SAMPLE_BITS     = 16;
  localparam int LATENCY         = CORDIC_STEPS + 6;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int N_DIRECTED      = 21;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic signed [SAMPLE_BITS-1:0] mag_x;
  logic signed [SAMPLE_BITS-1:0] mag_y;
  logic                          wr_en;
  logic [1:0]                    wr_index;
  logic [15:0]                   wr_data;
  logic                          done;
  logic [14:0]                   heading;
  logic                          y_saturated;

  int mismatches;
  int pending;
  int cycles;
  int idle_pct;

  // Offsets last written, so that requests can land near the corrected origin.
  logic signed [15:0] cur_off_x;
  logic signed [15:0] cur_off_y;

  // Zero vector, axes, full-scale corners, vectors just off the X axis and unit diagonals.
  logic signed [15:0] dir_x [N_DIRECTED] = '{
    16'sd0, 16'sd100, 16'sd0, -16'sd100, 16'sd0,
    16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
    16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
    16'sd1, -16'sd1, 16'sd1, -16'sd1,
    16'sd0, 16'sd0, 16'sh8000, 16'sh7FFF
  };
  logic signed [15:0] dir_y [N_DIRECTED] = '{
    16'sd0, 16'sd0, 16'sd100, 16'sd0, -16'sd100,
    16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF,
    -16'sd1, 16'sd1, -16'sd1, 16'sd1,
    16'sd1, -16'sd1, -16'sd1, 16'sd1,
    16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0
  };

  compass_heading_calc #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .mag_x      (mag_x),
    .mag_y      (mag_y),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .done       (done),
    .heading    (heading),
    .y_saturated(y_saturated)
  );

  compass_heading_checker #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) chk (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .mag_x      (mag_x),
    .mag_y      (mag_y),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .done       (done),
    .heading    (heading),
    .y_saturated(y_saturated),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_request(input logic signed [15:0] x, input logic signed [15:0] y);
    @(negedge clk);
    start <= 1'b1;
    mag_x <= x;
    mag_y <= y;
    do @(posedge clk); while (busy);
  endtask

  // Holds start low for a pause whose length is given by n; the sample ports carry noise meanwhile.
  task automatic pause(input int n);
    @(negedge clk);
    start <= 1'b0;
    mag_x <= 16'($urandom);
    mag_y <= 16'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input cch_reg_t idx, input logic [15:0] val);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    if (idx == REG_OFFSET_X) cur_off_x = val;
    if (idx == REG_OFFSET_Y) cur_off_y = val;
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic configure(input logic [15:0] ox, input logic [15:0] oy,
                           input logic [15:0] sc, input logic [15:0] mo);
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
    write_reg(REG_SCALE_Y, sc);
    write_reg(REG_MOUNT_OFFSET, mo);
  endtask

  function automatic logic [15:0] pick_extreme();
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'hFFFF;
      2:       return 16'h0000;
      3:       return 16'h0001;
      default: return 16'h7FFF;
    endcase
  endfunction

  // Offset plus a small signed delta, wrapped to the sample width.
  function automatic logic [15:0] near_offset(input logic signed [15:0] off, input int span);
    int v;
    v = int'(off) + int'($urandom_range(0, 2 * span)) - span;
    return v[15:0];
  endfunction

  task automatic send_random();
    logic [15:0] x, y;
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      x = 16'($urandom);
      y = 16'($urandom);
    end else if (kind < 55) begin
      x = near_offset(cur_off_x, 3);
      y = near_offset(cur_off_y, 3);
    end else if (kind < 70) begin
      x = near_offset(cur_off_x, 64);
      y = near_offset(cur_off_y, 64);
    end else if (kind < 85) begin
      // At least one corrected axis exactly zero.
      if ($urandom_range(0, 1) == 0) begin
        x = cur_off_x;
        y = ($urandom_range(0, 3) == 0) ? cur_off_y : 16'($urandom);
      end else begin
        x = 16'($urandom);
        y = cur_off_y;
      end
    end else begin
      x = pick_extreme();
      y = pick_extreme();
    end
    send_request(x, y);
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    mag_x     = '0;
    mag_y     = '0;
    wr_en     = 1'b0;
    wr_index  = '0;
    wr_data   = '0;
    cur_off_x = '0;
    cur_off_y = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed requests under the reset calibration.
    for (int i = 0; i < N_DIRECTED; i++) begin
      if ($urandom_range(0, 2) == 0)
        pause($urandom_range(1, 6));
      send_request(dir_x[i], dir_y[i]);
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain();
        case (p)
          1: configure(16'h7FFF, 16'h8000, 16'hFFFF, 16'(23039));
          2: configure(16'h8000, 16'h7FFF, 16'h0000, 16'(-23039));
          // Mount offsets beyond a full turn must still wrap.
          3: configure(16'h0000, 16'h0000, 16'hFFFF, 16'h8000);
          4: configure(16'($urandom), 16'($urandom), 16'd4096, 16'h7FFF);
          5: configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
          6: configure(16'(int'($urandom_range(0, 400)) - 200),
                       16'(int'($urandom_range(0, 400)) - 200),
                       16'($urandom_range(2048, 8192)),
                       16'(int'($urandom_range(0, 46078)) - 23039));
          default: configure(16'hFFFF, 16'hFFFF, 16'h0001, 16'hFFFF);
        endcase
      end
      if (p == PHASES - 1)
        idle_pct = 0;
      else
        idle_pct = 25 * $urandom_range(0, 2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 99) < idle_pct)
          pause($urandom_range(1, 6));
        send_random();
      end
    end

    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/cch_pkg.sv
rtl/cch_cordic_stage.sv
rtl/compass_heading_calc.sv
tb/sv/compass_heading_checker.sv
tb/sv/tb_compass_heading_calc.sv
